/* rtl/tqwl_pkg.sv */
// shared types and constants for the texture wrap and lod block
package tqwl_pkg;

  localparam int unsigned CoordFracBitsDef = 16;
  localparam int unsigned LodFracBitsDef   = 8;
  localparam int unsigned CfgAddrW         = 3;
  localparam int unsigned CfgDataW         = 14;

  localparam logic [CfgAddrW-1:0] CfgWrapS   = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgWrapT   = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgMinify  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgMagnify = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgWidth   = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgHeight  = 3'd5;
  localparam logic [CfgAddrW-1:0] CfgMaxLvl  = 3'd6;

  localparam logic [1:0] WrapClamp  = 2'd0;
  localparam logic [1:0] WrapRepeat = 2'd1;
  localparam logic [1:0] WrapMirror = 2'd2;

  localparam logic [2:0] MinNearMipNear = 3'd2;
  localparam logic [2:0] MinLinMipNear  = 3'd3;
  localparam logic [2:0] MinNearMipLin  = 3'd4;

  typedef struct packed {
    logic signed [31:0] s_top_left;
    logic signed [31:0] s_top_right;
    logic signed [31:0] s_bottom_left;
    logic signed [31:0] s_bottom_right;
    logic signed [31:0] t_top_left;
    logic signed [31:0] t_top_right;
    logic signed [31:0] t_bottom_left;
    logic signed [31:0] t_bottom_right;
  } quad_req_t;

  typedef struct packed {
    logic [1:0]         fragment_index;
    logic [16:0]        wrapped_s;
    logic [16:0]        wrapped_t;
    logic signed [15:0] level_of_detail;
    logic               is_magnify;
    logic [3:0]         nearest_level;
    logic               last_of_quad;
  } frag_res_t;

  typedef struct packed {
    logic [1:0]  wrap_s;
    logic [1:0]  wrap_t;
    logic [2:0]  minify;
    logic        magnify;
    logic [13:0] width;
    logic [13:0] height;
    logic [3:0]  max_level;
  } cfg_t;

endpackage

/* rtl/tqwl_if.sv */
// valid/ready channel carrying one payload type
interface tqwl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tqwl_lod.sv */
// pipelined level-of-detail unit: squared length to log2 of the length, less CoordFracBits, in signed q.lod_frac_bits
module tqwl_lod import tqwl_pkg::*; #(
  parameter int unsigned CoordFracBits = CoordFracBitsDef,
  parameter int unsigned LodFracBits   = LodFracBitsDef
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [93:0]        sq_i,
  output logic signed [15:0] lod_o
);
  // stage a: top bit search and normalise
  logic [6:0]  p_d, p_q;
  logic [31:0] m_d, m_q;
  logic        z_d, z_q;
  logic [188:0] sh;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < 94; i++) begin
      if (sq_i[i]) p_d = 7'(i);
    end
    z_d = (sq_i == '0);
    sh  = {95'd0, sq_i} << 7'(94 - 1 - p_d);
    // mantissa in 1.31 with the leading one kept at bit 31
    m_d = sh[93:62];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      m_q <= m_d;
      z_q <= z_d;
    end
  end

  // stages: one squaring per stage, registered
  logic [31:0]            m_s [LodFracBits+1];
  logic [LodFracBits-1:0] f_s [LodFracBits+1];
  logic [6:0]             p_s [LodFracBits+1];
  logic                   z_s [LodFracBits+1];

  assign m_s[0] = m_q;
  assign f_s[0] = '0;
  assign p_s[0] = p_q;
  assign z_s[0] = z_q;

  for (genvar g = 0; g < LodFracBits; g++) begin : g_sq
    logic [63:0] prod;
    logic [32:0] sq;
    logic [31:0] m_n_q;
    logic [LodFracBits-1:0] f_n_q;
    logic [6:0] p_n_q;
    logic z_n_q;
    assign prod = m_s[g] * m_s[g];
    assign sq   = prod[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_n_q <= sq[32] ? sq[32:1] : sq[31:0];
        f_n_q <= {f_s[g][LodFracBits-2:0], sq[32]};
        p_n_q <= p_s[g];
        z_n_q <= z_s[g];
      end
    end
    assign m_s[g+1] = m_n_q;
    assign f_s[g+1] = f_n_q;
    assign p_s[g+1] = p_n_q;
    assign z_s[g+1] = z_n_q;
  end

  localparam int signed Bias = CoordFracBits << LodFracBits;
  logic signed [23:0] lf, lod;
  always_comb begin
    lf  = 24'({p_s[LodFracBits], f_s[LodFracBits]});
    lod = (lf >>> 1) - 24'(Bias);
    if (z_s[LodFracBits])           lod_o = -16'sd32768;
    else if (lod > 24'sd32767)      lod_o = 16'sd32767;
    else if (lod < -24'sd32768)     lod_o = -16'sd32768;
    else                            lod_o = lod[15:0];
  end
endmodule

/* rtl/texture_quad_wrap_and_lod.sv */
// top level: quad wrap, derivative lengths, lod and fragment serialiser
// a quad request passes the wrap, scale, partial product, square and lod stages
// and then the serialiser register; one fragment result per cycle while frag_res is
//   ready, four per quad on the single result channel; quads overlap in the pipeline
// the pipeline stalls as a whole when its last stage cannot hand over
// a width or height write starts a 33 step clamp edge divide; requests wait for it
// reset: asynchronous active low, clears valid bits and config to defaults
module texture_quad_wrap_and_lod import tqwl_pkg::*; #(
  parameter int unsigned CoordFracBits = CoordFracBitsDef,
  parameter int unsigned LodFracBits   = LodFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  tqwl_if.sink                quad_req,
  tqwl_if.source              frag_res
);
  localparam int unsigned Depth    = LodFracBits + 5;
  localparam int unsigned DivSteps = 33;
  localparam logic [32:0] One = 33'd1 << CoordFracBits;

  // configuration registers
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{wrap_s: WrapRepeat, wrap_t: WrapRepeat, minify: MinNearMipNear,
                 magnify: 1'b1, width: 14'd1, height: 14'd1, max_level: 4'd0};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgWrapS:   cfg_q.wrap_s    <= cfg_wdata_i[1:0];
        CfgWrapT:   cfg_q.wrap_t    <= cfg_wdata_i[1:0];
        CfgMinify:  cfg_q.minify    <= cfg_wdata_i[2:0];
        CfgMagnify: cfg_q.magnify   <= cfg_wdata_i[0];
        CfgWidth:   cfg_q.width     <= cfg_wdata_i;
        CfgHeight:  cfg_q.height    <= cfg_wdata_i;
        CfgMaxLvl:  cfg_q.max_level <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  logic [13:0] w, h;
  assign w = (cfg_q.width == '0) ? 14'd1 : cfg_q.width;
  assign h = (cfg_q.height == '0) ? 14'd1 : cfg_q.height;

  // clamp edge per axis (0 for s, 1 for t): (one + n) / (2n) by a restoring
  // divider, one quotient bit a cycle, restarted on each width or height write
  logic [32:0] div_num_q [2], div_quo_q [2];
  logic [15:0] div_rem_q [2], div_den_q [2];
  logic [5:0]  div_cnt_q [2];
  logic [1:0]  div_start;
  logic [13:0] div_n;
  logic [15:0] div_try [2];
  logic        div_ge [2];
  logic        div_busy;

  assign div_n        = (cfg_wdata_i == '0) ? 14'd1 : cfg_wdata_i;
  assign div_start[0] = cfg_we_i && (cfg_addr_i == CfgWidth);
  assign div_start[1] = cfg_we_i && (cfg_addr_i == CfgHeight);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      div_try[a] = {div_rem_q[a][14:0], div_num_q[a][32]};
      div_ge[a]  = div_try[a] >= div_den_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 2; a++) begin
        // size one after reset: edge is half a texel step, one / 2
        div_num_q[a] <= '0;
        div_quo_q[a] <= One >> 1;
        div_rem_q[a] <= '0;
        div_den_q[a] <= 16'd2;
        div_cnt_q[a] <= '0;
      end
    end else begin
      for (int a = 0; a < 2; a++) begin
        if (div_start[a]) begin
          div_num_q[a] <= One + 33'(div_n);
          div_den_q[a] <= {1'b0, div_n, 1'b0};
          div_rem_q[a] <= '0;
          div_quo_q[a] <= '0;
          div_cnt_q[a] <= 6'(DivSteps);
        end else if (div_cnt_q[a] != '0) begin
          div_num_q[a] <= div_num_q[a] << 1;
          div_rem_q[a] <= div_ge[a] ? div_try[a] - div_den_q[a] : div_try[a];
          div_quo_q[a] <= {div_quo_q[a][31:0], div_ge[a]};
          div_cnt_q[a] <= div_cnt_q[a] - 6'd1;
        end
      end
    end
  end

  assign div_busy = (div_cnt_q[0] != '0) || (div_cnt_q[1] != '0);

  // pipeline valid bits, advance when the tail is empty or the serialiser takes it
  logic [Depth-1:0] vld_q;
  logic             adv;
  logic [1:0]       cnt_q;
  logic             out_vld_q;
  logic             ser_free;

  // serialiser is free when empty or handing over its last fragment
  assign ser_free = !out_vld_q || (frag_res.ready && cnt_q == 2'd3);
  assign adv = !vld_q[Depth-1] || ser_free;
  assign quad_req.ready = adv && !div_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], quad_req.valid && !div_busy};
  end

  // stage 1: differences and wrap, per fragment
  quad_req_t in;
  assign in = quad_req.data;
  logic signed [31:0] s [4], tt [4];
  assign s  = '{in.s_top_left, in.s_top_right, in.s_bottom_left, in.s_bottom_right};
  assign tt = '{in.t_top_left, in.t_top_right, in.t_bottom_left, in.t_bottom_right};

  function automatic logic [32:0] absdiff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(b) - 33'(a);
    return d[32] ? 33'(-d) : d;
  endfunction

  function automatic logic [16:0] wrap(logic signed [31:0] x, logic [1:0] mode,
                                       logic [32:0] lo);
    logic [32:0] hi, r;
    logic [31:0] frac;
    frac = 32'(x) & 32'(One - 33'd1);
    hi = One - lo;
    if (mode == WrapClamp) begin
      if ($signed({x[31], x}) < $signed(lo)) r = lo;
      else if ($signed({x[31], x}) > $signed(hi)) r = hi;
      else r = 33'(x);
    end else if (mode == WrapMirror && x[CoordFracBits]) r = One - 33'(frac);
    else r = 33'(frac);
    if (CoordFracBits >= 16) r = r >> (CoordFracBits - 16);
    else r = r << (16 - CoordFracBits);
    return r[16:0];
  endfunction

  // clamp edges come from the divider, settled before any request is taken
  logic [32:0] dsx_d [2], dtx_d [2], dsy_d [2], dty_d [2];
  logic [32:0] dsx_q [2], dtx_q [2], dsy_q [2], dty_q [2];
  logic [16:0] ws_q [Depth][4], wt_q [Depth][4];
  for (genvar k = 0; k < 2; k++) begin : g_diff
    assign dsx_d[k] = absdiff(s[2*k], s[2*k+1]);
    assign dtx_d[k] = absdiff(tt[2*k], tt[2*k+1]);
    assign dsy_d[k] = absdiff(s[k], s[k+2]);
    assign dty_d[k] = absdiff(tt[k], tt[k+2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsx_q <= dsx_d; dtx_q <= dtx_d; dsy_q <= dsy_d; dty_q <= dty_d;
      for (int k = 0; k < 4; k++) begin
        ws_q[0][k] <= wrap(s[k], cfg_q.wrap_s, div_quo_q[0]);
        wt_q[0][k] <= wrap(tt[k], cfg_q.wrap_t, div_quo_q[1]);
      end
      for (int d = 1; d < Depth; d++) begin
        ws_q[d] <= ws_q[d-1];
        wt_q[d] <= wt_q[d-1];
      end
    end
  end

  // stage 2: scale by texture size
  logic [46:0] sc_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        sc_q[k]   <= 47'(dsx_q[k]) * 47'(w);
        sc_q[2+k] <= 47'(dtx_q[k]) * 47'(h);
        sc_q[4+k] <= 47'(dsy_q[k]) * 47'(w);
        sc_q[6+k] <= 47'(dty_q[k]) * 47'(h);
      end
    end
  end

  // stage 3: partial products of each square on a 24 bit low and a 23 bit high half
  logic [47:0] p00_q [8];
  logic [46:0] p01_q [8];
  logic [45:0] p11_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        p00_q[k] <= 48'(sc_q[k][23:0]) * 48'(sc_q[k][23:0]);
        p01_q[k] <= 47'(sc_q[k][23:0]) * 47'(sc_q[k][46:24]);
        p11_q[k] <= 46'(sc_q[k][46:24]) * 46'(sc_q[k][46:24]);
      end
    end
  end

  // stage 4: full squares, then sums and max per fragment ahead of the lod pipe
  logic [93:0] sq_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        sq_q[k] <= (94'(p11_q[k]) << 48) + (94'(p01_q[k]) << 25) + 94'(p00_q[k]);
      end
    end
  end

  logic [93:0] lx [2], ly [2], mx [4];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lx[k] = sq_q[k] + sq_q[2+k];
      ly[k] = sq_q[4+k] + sq_q[6+k];
    end
    for (int k = 0; k < 4; k++) begin
      mx[k] = (lx[k>>1] >= ly[k&1]) ? lx[k>>1] : ly[k&1];
    end
  end

  // one lod pipe per fragment
  logic signed [15:0] lod [4];
  for (genvar k = 0; k < 4; k++) begin : g_lod
    tqwl_lod #(.CoordFracBits(CoordFracBits), .LodFracBits(LodFracBits)) u_lod (
      .clk_i (clk_i),
      .en_i  (adv),
      .sq_i  (mx[k]),
      .lod_o (lod[k])
    );
  end

  // serialiser: holds one quad and emits four fragment results
  logic [16:0]        os_q [4], ot_q [4];
  logic signed [15:0] ol_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else if (vld_q[Depth-1] && ser_free) begin
      out_vld_q <= 1'b1;
      cnt_q     <= '0;
    end else if (out_vld_q && frag_res.ready) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[Depth-1] && ser_free) begin
      os_q <= ws_q[Depth-1];
      ot_q <= wt_q[Depth-1];
      ol_q <= lod;
    end
  end

  // per fragment magnify flag and nearest level
  localparam int signed Half = 1 << (LodFracBits - 1);
  logic signed [15:0] cur;
  logic signed [17:0] c_thr, top, lvl;
  logic mip_near;
  frag_res_t res;
  always_comb begin
    cur = ol_q[cnt_q];
    mip_near = (cfg_q.minify == MinNearMipNear) || (cfg_q.minify == MinLinMipNear);
    c_thr = (cfg_q.magnify && (cfg_q.minify == MinNearMipNear ||
             cfg_q.minify == MinNearMipLin)) ? 18'(Half) : 18'sd0;
    top = 18'(({14'd0, cfg_q.max_level} << LodFracBits) + Half);
    lvl = ((18'(cur) + 18'(Half) + 18'((1 << LodFracBits) - 1)) >>> LodFracBits)
          - 18'sd1;
    res.fragment_index  = cnt_q;
    res.wrapped_s       = os_q[cnt_q];
    res.wrapped_t       = ot_q[cnt_q];
    res.level_of_detail = cur;
    res.is_magnify      = 18'(cur) <= c_thr;
    res.last_of_quad    = cnt_q == 2'd3;
    if (!mip_near || 18'(cur) <= 18'(Half)) res.nearest_level = '0;
    else if (18'(cur) > top)               res.nearest_level = cfg_q.max_level;
    else                                    res.nearest_level = lvl[3:0];
  end

  assign frag_res.valid = out_vld_q;
  assign frag_res.data  = res;

  // last flag only on the fourth result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frag_res.valid && frag_res.data.last_of_quad |-> frag_res.data.fragment_index == 2'd3)
    else $error("last flag off the fourth fragment");
  // a delivered last fragment empties the serialiser unless refilled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frag_res.valid && frag_res.ready && cnt_q == 2'd3 && !vld_q[Depth-1] |=> !out_vld_q)
    else $error("serialiser did not drain");
  // index steps by one on each handed over fragment within a quad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frag_res.valid && frag_res.ready && cnt_q != 2'd3 |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("fragment index skipped");
endmodule

/* verif/tb_top.sv */
// testbench for the texture quad wrap and lod block, with its own predictor and scoreboard
module tb_top;
  import tqwl_pkg::*;

  localparam int unsigned DrainCycles = LodFracBitsDef + 12;
  localparam int unsigned WatchLimit  = 4000;

  // scoreboard: predicts the four fragment results of each quad request and
  // checks results in order against them
  class quad_lod_board;
    cfg_t        regs;
    frag_res_t   pending[$];
    int unsigned errors;

    function new();
      regs   = '{wrap_s: WrapRepeat, wrap_t: WrapRepeat, minify: MinNearMipNear,
                 magnify: 1'b1, width: 14'd1, height: 14'd1, max_level: 4'd0};
      errors = 0;
    endfunction

    function logic [16:0] wrap_coord(longint x, logic [1:0] mode, longint n);
      longint      lo;
      longint      hi;
      longint      c;
      logic [63:0] r;
      if (mode == WrapClamp) begin
        lo = (65536 + n) / (2 * n);
        hi = 65536 - lo;
        c  = x < lo ? lo : (x > hi ? hi : x);
        r  = c;
      end else if (mode == WrapMirror && x[16]) begin
        r = 65536 - longint'(x[15:0]);
      end else begin
        r = x[15:0];
      end
      return r[16:0];
    endfunction

    function logic [127:0] len_sq(longint a0, longint a1, longint b0, longint b1,
                                  longint w, longint h);
      longint       ds;
      longint       dt;
      logic [127:0] ps;
      logic [127:0] pt;
      ds = a1 - a0;
      dt = b1 - b0;
      if (ds < 0) ds = -ds;
      if (dt < 0) dt = -dt;
      ps = 128'(ds * w);
      pt = 128'(dt * h);
      return ps * ps + pt * pt;
    endfunction

    function longint lod_of(logic [127:0] v);
      int          p;
      logic [63:0] m;
      logic [127:0] sh;
      longint      frac;
      longint      lod;
      if (v == 0) return -32768;
      p = 0;
      for (int i = 0; i < 128; i++) if (v[i]) p = i;
      sh = p >= 31 ? v >> (p - 31) : v << (31 - p);
      m  = {32'd0, sh[31:0]};
      frac = 0;
      // one extra fraction bit per squaring of the normalised mantissa
      for (int i = 0; i < LodFracBitsDef; i++) begin
        m    = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      lod = (((longint'(p) << LodFracBitsDef) | frac) >>> 1)
            - (longint'(CoordFracBitsDef) << LodFracBitsDef);
      if (lod > 32767) lod = 32767;
      if (lod < -32768) lod = -32768;
      return lod;
    endfunction

    function void note_quad(quad_req_t q);
      longint       s[4];
      longint       t[4];
      logic [127:0] sqx[2];
      logic [127:0] sqy[2];
      longint       w;
      longint       h;
      longint       half;
      longint       thr;
      longint       top;
      longint       lod;
      longint       lvl;
      logic [127:0] qa;
      logic [127:0] qb;
      frag_res_t    r;
      w = regs.width == 0 ? 1 : regs.width;
      h = regs.height == 0 ? 1 : regs.height;
      s = '{q.s_top_left, q.s_top_right, q.s_bottom_left, q.s_bottom_right};
      t = '{q.t_top_left, q.t_top_right, q.t_bottom_left, q.t_bottom_right};
      half = longint'(1) << (LodFracBitsDef - 1);
      thr  = (regs.magnify && (regs.minify == MinNearMipNear || regs.minify == MinNearMipLin))
             ? half : 0;
      top  = (longint'(regs.max_level) << LodFracBitsDef) + half;
      for (int k = 0; k < 2; k++) begin
        // rows give the x derivative, columns the y derivative
        sqx[k] = len_sq(s[2*k], s[2*k+1], t[2*k], t[2*k+1], w, h);
        sqy[k] = len_sq(s[k], s[k+2], t[k], t[k+2], w, h);
      end
      for (int k = 0; k < 4; k++) begin
        qa  = sqx[k >> 1];
        qb  = sqy[k & 1];
        lod = lod_of(qa >= qb ? qa : qb);
        lvl = 0;
        if (regs.minify == MinNearMipNear || regs.minify == MinLinMipNear) begin
          if (lod <= half) lvl = 0;
          else if (lod > top) lvl = regs.max_level;
          else lvl = ((lod + half + (longint'(1) << LodFracBitsDef) - 1) >>> LodFracBitsDef) - 1;
        end
        r.fragment_index  = k[1:0];
        r.wrapped_s       = wrap_coord(s[k], regs.wrap_s, w);
        r.wrapped_t       = wrap_coord(t[k], regs.wrap_t, h);
        r.level_of_detail = lod[15:0];
        r.is_magnify      = lod <= thr;
        r.nearest_level   = lvl[3:0];
        r.last_of_quad    = k == 3;
        pending.push_back(r);
      end
    endfunction

    function void cmp(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s expected %0d got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_frag(frag_res_t a);
      frag_res_t e;
      if (pending.size() == 0) begin
        $error("fragment result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("fragment_index", e.fragment_index, a.fragment_index);
      cmp("wrapped_s", e.wrapped_s, a.wrapped_s);
      cmp("wrapped_t", e.wrapped_t, a.wrapped_t);
      cmp("level_of_detail", e.level_of_detail, a.level_of_detail);
      cmp("is_magnify", e.is_magnify, a.is_magnify);
      cmp("nearest_level", e.nearest_level, a.nearest_level);
      cmp("last_of_quad", e.last_of_quad, a.last_of_quad);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  tqwl_if #(.T(quad_req_t)) quad_if ();
  tqwl_if #(.T(frag_res_t)) frag_if ();

  texture_quad_wrap_and_lod dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .quad_req   (quad_if),
    .frag_res   (frag_if)
  );

  quad_lod_board board = new();
  int unsigned   idle_pct  = 0;
  int unsigned   stall_pct = 0;
  int unsigned   quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  initial begin
    quad_if.valid = 1'b0;
    quad_if.data  = '0;
    frag_if.ready = 1'b0;
  end

  // request monitor: quads are predicted as they are accepted
  always @(posedge clk_i) begin
    if (quad_if.valid && quad_if.ready) board.note_quad(quad_if.data);
  end

  // result side: random stalls, check each accepted fragment
  always @(posedge clk_i) begin
    if (frag_if.valid && frag_if.ready) board.check_frag(frag_if.data);
    frag_if.ready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((quad_if.valid && quad_if.ready) || (frag_if.valid && frag_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // send one quad request, leaving valid high after acceptance
  task automatic send_quad(quad_req_t q);
    while ($urandom_range(0, 99) < idle_pct) begin
      quad_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    quad_if.valid <= 1'b1;
    quad_if.data  <= q;
    do @(posedge clk_i); while (!quad_if.ready);
  endtask

  // lower valid and wait for all fragments plus the pipeline tail
  task automatic drain();
    quad_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgWrapS:   board.regs.wrap_s    = val[1:0];
      CfgWrapT:   board.regs.wrap_t    = val[1:0];
      CfgMinify:  board.regs.minify    = val[2:0];
      CfgMagnify: board.regs.magnify   = val[0];
      CfgWidth:   board.regs.width     = val[13:0];
      CfgHeight:  board.regs.height    = val[13:0];
      CfgMaxLvl:  board.regs.max_level = val[3:0];
      default: ;  // unused index, block ignores it
    endcase
  endtask

  task automatic cfg_all(int ws, int wt, int mn, int mg, int w, int h, int ml);
    cfg_write(CfgWrapS, CfgDataW'(ws));
    cfg_write(CfgWrapT, CfgDataW'(wt));
    cfg_write(CfgMinify, CfgDataW'(mn));
    cfg_write(CfgMagnify, CfgDataW'(mg));
    cfg_write(CfgWidth, CfgDataW'(w));
    cfg_write(CfgHeight, CfgDataW'(h));
    cfg_write(CfgMaxLvl, CfgDataW'(ml));
  endtask

  function automatic quad_req_t quad_of(int sa, int sb, int sc, int sd,
                                        int ta, int tb, int tc, int td);
    quad_req_t q;
    q = '{sa, sb, sc, sd, ta, tb, tc, td};
    return q;
  endfunction

  // mostly coherent quads with a random footprint, some pure noise
  function automatic quad_req_t rand_quad();
    quad_req_t q;
    int        bs;
    int        bt;
    int        spread;
    q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 4) != 0) begin
      bs     = $urandom;
      bt     = $urandom;
      if ($urandom_range(0, 1)) begin
        bs = bs >>> 12;
        bt = bt >>> 12;
      end
      spread = 1 << $urandom_range(0, 22);
      q.s_top_left     = bs + $urandom_range(0, spread);
      q.s_top_right    = bs + $urandom_range(0, spread);
      q.s_bottom_left  = bs + $urandom_range(0, spread);
      q.s_bottom_right = bs + $urandom_range(0, spread);
      q.t_top_left     = bt + $urandom_range(0, spread);
      q.t_top_right    = bt + $urandom_range(0, spread);
      q.t_bottom_left  = bt + $urandom_range(0, spread);
      q.t_bottom_right = bt + $urandom_range(0, spread);
    end
    return q;
  endfunction

  function automatic int rand_size();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 8192;
      2: return $urandom_range(8193, 16383);
      3: return 1;
      default: return 1 << $urandom_range(0, 10);
    endcase
  endfunction

  quad_req_t directed[8];

  initial begin
    // zero derivatives, extremes, sign and mirror parity, half texel steps
    directed[0] = quad_of(0, 0, 0, 0, 0, 0, 0, 0);
    directed[1] = quad_of(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    directed[2] = quad_of(-1, 32'h10000, 32'h1ffff, -32'h10000,
                          32'h18000, 32'h8000, -32'h8000, 32'h20000);
    directed[3] = quad_of(0, 32'h100, 0, 32'h100, 0, 0, 32'h100, 32'h100);
    directed[4] = quad_of(32'h10000, 32'h10000, 32'h10000, 32'h10000,
                          32'h30000, 32'h30001, 32'h30000, 32'h30001);
    directed[5] = quad_of(5, 5, 5, 5, 7, 7, 7, 7);
    directed[6] = quad_of(32'h8000, 32'h18000, 32'h8000, 32'h18000,
                          32'h4000, 32'h4000, 32'h44000, 32'h44000);
    directed[7] = quad_of(-32'h12345, -32'h12345, 32'h55555, 32'h55555,
                          32'h7fff0000, 32'h7fff0040, 32'h7fff0000, 32'h7fff0080);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings first, then clamp and mirror at the size extremes
    foreach (directed[i]) send_quad(directed[i]);
    drain();
    cfg_all(WrapClamp, WrapMirror, MinLinMipNear, 1, 8192, 1, 13);
    foreach (directed[i]) send_quad(directed[i]);
    drain();
    // wrap mode 3, unmapped minify code, zero width, maximum height, oversize level, spare index
    cfg_all(3, WrapClamp, 7, 0, 0, 16383, 15);
    cfg_write(3'd7, 14'h3fff);
    foreach (directed[i]) send_quad(directed[i]);
    drain();

    for (int b = 0; b < 8; b++) begin
      case (b % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      cfg_all($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 7),
              $urandom_range(0, 1), rand_size(), rand_size(), $urandom_range(0, 15));
      for (int i = 0; i < 50; i++) begin
        // hold off once mid-batch until the pipeline is empty
        if (b == 1 && i == 25) begin
          quad_if.valid <= 1'b0;
          @(posedge clk_i);
          while (board.pending.size() != 0) @(posedge clk_i);
        end
        send_quad(rand_quad());
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* texture_quad_wrap_and_lod.f */
rtl/tqwl_pkg.sv
rtl/tqwl_if.sv
rtl/tqwl_lod.sv
rtl/texture_quad_wrap_and_lod.sv
verif/tb_top.sv
